// ----- sv/jdcm_pkg.sv -----
// Shared types, widths and constants for the joystick deadzone chassis mapper.
`timescale 1ns / 1ps
`default_nettype none

package jdcm_pkg;

   // Raw axis sample width (signed, SAMPLE_BITS-1 fraction bits)
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths
   localparam int COUNT_W   = 4;
   localparam int CFG_W     = 15;
   localparam int MAG_W     = 16;                 // Q0.15 magnitude, up to 1.0 inclusive
   localparam int P1_W      = MAG_W + CFG_W;      // diff * gain
   localparam int P2_W      = P1_W + CFG_W;       // diff * gain * limit
   localparam int RND_SHIFT = 26;
   localparam int RND_W     = P2_W - RND_SHIFT + 1;
   localparam int OUT_W     = 16;
   localparam int AXES      = 6;
   localparam int LANES     = 3;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_DEADZONE_LEVEL = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DEADZONE_GAIN  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_VELOCITY_LIMIT = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROTATION_LIMIT = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0] RST_DEADZONE_LEVEL = 15'd3277;
   localparam logic [CFG_W-1:0] RST_DEADZONE_GAIN  = 15'd2276;
   localparam logic [CFG_W-1:0] RST_VELOCITY_LIMIT = 15'd256;
   localparam logic [CFG_W-1:0] RST_ROTATION_LIMIT = 15'd256;

   // Layout selecting axis counts
   localparam logic [COUNT_W-1:0] COUNT_THREE = 4'd3;
   localparam logic [COUNT_W-1:0] COUNT_SIX   = 4'd6;

   // Output lane order
   localparam int LANE_FORWARD = 0;
   localparam int LANE_SIDE    = 1;
   localparam int LANE_TURN    = 2;

   typedef struct packed {
      logic [CFG_W-1:0] deadzone_level;
      logic [CFG_W-1:0] deadzone_gain;
      logic [CFG_W-1:0] velocity_limit;
      logic [CFG_W-1:0] rotation_limit;
   } cfg_type;

   // Sign and aligned magnitude of one axis
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } axis_type;

   // One output lane: sign and magnitude past the deadzone
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] diff;
   } lane_type;

   // Beat from the selection stages into the shaping stages
   typedef struct packed {
      logic                  valid;
      lane_type [LANES-1:0]  lane;
   } sel_beat_type;

   // Split a raw sample into sign and Q0.15 magnitude
   function automatic axis_type decode_axis(input logic [SAMPLE_BITS-1:0] raw);
      axis_type                    res;
      logic [SAMPLE_BITS-1:0]      m;
      logic [SAMPLE_BITS+14:0]     wide;
      logic [SAMPLE_BITS+14:0]     shifted;
      res.neg = raw[SAMPLE_BITS-1];
      m       = res.neg ? (~raw + 1'b1) : raw;
      wide    = {m, 15'd0};
      shifted = wide >> (SAMPLE_BITS - 1);
      res.mag = shifted[MAG_W-1:0];
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/jdcm_if.sv -----
// Valid/ready channel interfaces for gamepad samples and speed commands.
`timescale 1ns / 1ps
`default_nettype none

interface jdcm_req_if import jdcm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic        [COUNT_W-1:0]      axis_count;
   logic signed [SAMPLE_BITS-1:0]  axis_zero;
   logic signed [SAMPLE_BITS-1:0]  axis_one;
   logic signed [SAMPLE_BITS-1:0]  axis_two;
   logic signed [SAMPLE_BITS-1:0]  axis_three;
   logic signed [SAMPLE_BITS-1:0]  axis_four;
   logic signed [SAMPLE_BITS-1:0]  axis_five;

   modport source (output valid, axis_count, axis_zero, axis_one, axis_two,
                   axis_three, axis_four, axis_five, input ready);
   modport sink   (input valid, axis_count, axis_zero, axis_one, axis_two,
                   axis_three, axis_four, axis_five, output ready);
endinterface

interface jdcm_rsp_if import jdcm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  forward_speed;
   logic signed [OUT_W-1:0]  side_speed;
   logic signed [OUT_W-1:0]  turn_rate;

   modport source (output valid, forward_speed, side_speed, turn_rate, input ready);
   modport sink   (input valid, forward_speed, side_speed, turn_rate, output ready);
endinterface

`default_nettype wire

// ----- sv/joystick_deadzone_chassis_mapper.sv -----
// Throughput: one sample per cycle while rsp is ready; five register stages
// (decode, select, gain multiply, limit multiply, round/saturate) each hold
// one beat. A stall on rsp holds every full stage in place and lets empty
// stages fill; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults: deadzone 0.1, gain 2276, both limits 256.
`timescale 1ns / 1ps
`default_nettype none

module joystick_deadzone_chassis_mapper
   import jdcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   jdcm_req_if.sink                    req_bus,
   jdcm_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   cfg_type       cfg;
   sel_beat_type  sel_beat;
   logic          sel_ready;

   // Configuration registers
   jdcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Decode and layout selection
   jdcm_select u_select (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_bus   (req_bus),
      .sel_beat  (sel_beat),
      .sel_ready (sel_ready)
   );

   // Scaling, rounding and saturation
   jdcm_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .sel_beat  (sel_beat),
      .sel_ready (sel_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- sv/jdcm_csr.sv -----
// APB-style configuration registers for the deadzone and limits.
`timescale 1ns / 1ps
`default_nettype none

module jdcm_csr
   import jdcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output cfg_type                     cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   idx;

   assign idx        = csr_paddr[REG_IDX_W+1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DEADZONE_LEVEL: cfg_in.deadzone_level = csr_pwdata[CFG_W-1:0];
            REG_DEADZONE_GAIN:  cfg_in.deadzone_gain  = csr_pwdata[CFG_W-1:0];
            REG_VELOCITY_LIMIT: cfg_in.velocity_limit = csr_pwdata[CFG_W-1:0];
            REG_ROTATION_LIMIT: cfg_in.rotation_limit = csr_pwdata[CFG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone_level <= RST_DEADZONE_LEVEL;
         cfg_ff.deadzone_gain  <= RST_DEADZONE_GAIN;
         cfg_ff.velocity_limit <= RST_VELOCITY_LIMIT;
         cfg_ff.rotation_limit <= RST_ROTATION_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_DEADZONE_LEVEL: csr_prdata[CFG_W-1:0] = cfg_ff.deadzone_level;
         REG_DEADZONE_GAIN:  csr_prdata[CFG_W-1:0] = cfg_ff.deadzone_gain;
         REG_VELOCITY_LIMIT: csr_prdata[CFG_W-1:0] = cfg_ff.velocity_limit;
         REG_ROTATION_LIMIT: csr_prdata[CFG_W-1:0] = cfg_ff.rotation_limit;
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/jdcm_select.sv -----
// Stages one and two: axis decode, deadzone test and layout selection.
`timescale 1ns / 1ps
`default_nettype none

module jdcm_select
   import jdcm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   jdcm_req_if.sink     req_bus,
   output sel_beat_type sel_beat,
   input  wire logic    sel_ready
);

   // Stage one registers
   logic                  s1_valid_ff;
   axis_type [AXES-1:0]   s1_axis_ff;
   logic     [AXES-1:0]   s1_idle_ff;
   logic                  s1_none_ff;
   logic                  s1_six_ff;
   logic                  s1_above_ff;

   // Stage two registers
   logic                  s2_valid_ff;
   lane_type [LANES-1:0]  s2_lane_ff;

   logic                  s1_en;
   logic                  s2_en;
   axis_type [AXES-1:0]   s1_axis_in;
   logic     [AXES-1:0]   s1_idle_in;
   lane_type [LANES-1:0]  s2_lane_in;
   axis_type              fwd_ax;
   axis_type              side_ax;
   axis_type              rot_ax;
   logic                  fwd_idle;
   logic                  side_idle;
   logic                  rot_idle;

   // Stall chain: a stage loads when empty or when its contents move on
   assign s2_en         = !s2_valid_ff || sel_ready;
   assign s1_en         = !s1_valid_ff || s2_en;
   assign req_bus.ready = s1_en;

   // Decode all six axes and test each against the deadzone
   always_comb begin
      s1_axis_in[0] = decode_axis(req_bus.axis_zero);
      s1_axis_in[1] = decode_axis(req_bus.axis_one);
      s1_axis_in[2] = decode_axis(req_bus.axis_two);
      s1_axis_in[3] = decode_axis(req_bus.axis_three);
      s1_axis_in[4] = decode_axis(req_bus.axis_four);
      s1_axis_in[5] = decode_axis(req_bus.axis_five);
      for (int i = 0; i < AXES; i++) begin
         s1_idle_in[i] = s1_axis_in[i].mag < {1'b0, cfg.deadzone_level};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_axis_ff  <= s1_axis_in;
         s1_idle_ff  <= s1_idle_in;
         s1_none_ff  <= req_bus.axis_count < COUNT_THREE;
         s1_six_ff   <= req_bus.axis_count == COUNT_SIX;
         s1_above_ff <= req_bus.axis_count > COUNT_THREE;
      end
   end

   // Layout selection with six-axis fallbacks; other counts above three turn on axis 3
   always_comb begin
      fwd_ax    = s1_axis_ff[1];
      fwd_idle  = s1_idle_ff[1];
      side_ax   = s1_axis_ff[0];
      side_idle = s1_idle_ff[0];
      rot_ax    = s1_axis_ff[2];
      rot_idle  = s1_idle_ff[2];
      if (s1_six_ff) begin
         if (s1_idle_ff[2] && !s1_idle_ff[3]) begin
            rot_ax   = s1_axis_ff[3];
            rot_idle = s1_idle_ff[3];
         end
         if (s1_idle_ff[0] && s1_idle_ff[1] && (!s1_idle_ff[4] || !s1_idle_ff[5])) begin
            side_ax   = s1_axis_ff[4];
            side_idle = s1_idle_ff[4];
            fwd_ax    = s1_axis_ff[5];
            fwd_idle  = s1_idle_ff[5];
         end
      end else if (s1_above_ff) begin
         rot_ax   = s1_axis_ff[3];
         rot_idle = s1_idle_ff[3];
      end
   end

   // Remove the deadzone; idle axes and small counts become a clean zero
   always_comb begin
      s2_lane_in[LANE_FORWARD].neg  = fwd_ax.neg;
      s2_lane_in[LANE_FORWARD].diff = fwd_ax.mag - {1'b0, cfg.deadzone_level};
      s2_lane_in[LANE_SIDE].neg     = side_ax.neg;
      s2_lane_in[LANE_SIDE].diff    = side_ax.mag - {1'b0, cfg.deadzone_level};
      s2_lane_in[LANE_TURN].neg     = rot_ax.neg;
      s2_lane_in[LANE_TURN].diff    = rot_ax.mag - {1'b0, cfg.deadzone_level};
      if (fwd_idle || s1_none_ff) begin
         s2_lane_in[LANE_FORWARD] = '0;
      end
      if (side_idle || s1_none_ff) begin
         s2_lane_in[LANE_SIDE] = '0;
      end
      if (rot_idle || s1_none_ff) begin
         s2_lane_in[LANE_TURN] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_lane_ff <= s2_lane_in;
      end
   end

   assign sel_beat.valid = s2_valid_ff;
   assign sel_beat.lane  = s2_lane_ff;

endmodule

`default_nettype wire

// ----- sv/jdcm_shape.sv -----
// Stages three to five: gain multiply, limit multiply, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module jdcm_shape
   import jdcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire sel_beat_type sel_beat,
   output logic              sel_ready,
   jdcm_rsp_if.source        rsp_bus
);

   logic                    s3_valid_ff;
   logic                    s4_valid_ff;
   logic                    s5_valid_ff;
   logic [LANES-1:0]        s3_neg_ff;
   logic [LANES-1:0]        s4_neg_ff;
   logic [P1_W-1:0]         s3_prod_ff [LANES];
   logic [P2_W-1:0]         s4_prod_ff [LANES];
   logic [OUT_W-1:0]        s5_out_ff  [LANES];

   logic                    s3_en;
   logic                    s4_en;
   logic                    s5_en;
   logic [CFG_W-1:0]        limit      [LANES];
   logic [P1_W-1:0]         s3_prod_in [LANES];
   logic [P2_W-1:0]         s4_prod_in [LANES];
   logic [OUT_W-1:0]        s5_out_in  [LANES];

   assign s5_en     = !s5_valid_ff || rsp_bus.ready;
   assign s4_en     = !s4_valid_ff || s5_en;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign sel_ready = s3_en;

   assign limit[LANE_FORWARD] = cfg.velocity_limit;
   assign limit[LANE_SIDE]    = cfg.velocity_limit;
   assign limit[LANE_TURN]    = cfg.rotation_limit;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_en) s3_valid_ff <= sel_beat.valid;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Per-lane datapath
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [P2_W:0]    rounded;
         logic [RND_W-1:0] mag;
         logic [OUT_W:0]   neg_val;
         rounded = {1'b0, s4_prod_ff[i]} + ((P2_W+1)'(1) << (RND_SHIFT - 1));
         mag     = rounded[P2_W:RND_SHIFT];
         neg_val = '0;
         s3_prod_in[i] = P1_W'(sel_beat.lane[i].diff) * P1_W'(cfg.deadzone_gain);
         s4_prod_in[i] = P2_W'(s3_prod_ff[i]) * P2_W'(limit[i]);
         if (s4_neg_ff[i]) begin
            if (mag > RND_W'(32768)) begin
               mag = RND_W'(32768);
            end
            neg_val      = (OUT_W+1)'(17'h10000) - (OUT_W+1)'(mag);
            s5_out_in[i] = neg_val[OUT_W-1:0];
         end else begin
            if (mag > RND_W'(32767)) begin
               mag = RND_W'(32767);
            end
            s5_out_in[i] = mag[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (s3_en) begin
            s3_prod_ff[i] <= s3_prod_in[i];
            s3_neg_ff[i]  <= sel_beat.lane[i].neg;
         end
         if (s4_en) begin
            s4_prod_ff[i] <= s4_prod_in[i];
            s4_neg_ff[i]  <= s3_neg_ff[i];
         end
         if (s5_en) begin
            s5_out_ff[i] <= s5_out_in[i];
         end
      end
   end

   assign rsp_bus.valid         = s5_valid_ff;
   assign rsp_bus.forward_speed = s5_out_ff[LANE_FORWARD];
   assign rsp_bus.side_speed    = s5_out_ff[LANE_SIDE];
   assign rsp_bus.turn_rate     = s5_out_ff[LANE_TURN];

endmodule

`default_nettype wire
